/* rtl/dtrp_pkg.sv */
// Shared types, widths, codes and latency figures for the disparity registration pipeline.
package dtrp_pkg;

	// image size that a projected pixel must fall inside
	localparam int IMAGE_WIDTH  = 640;
	localparam int IMAGE_HEIGHT = 480;

	// field widths
	localparam int COL_W  = 10;
	localparam int ROW_W  = 9;
	localparam int DISP_W = 16;
	localparam int PT_W   = 32;
	localparam int ST_W   = 2;
	localparam int Z_W    = 31;

	// quotient bits of the projection divider; anything at or past 2^PROJ_QW is off image
	localparam int PROJ_QW = $clog2(IMAGE_WIDTH > IMAGE_HEIGHT ? IMAGE_WIDTH : IMAGE_HEIGHT);

	// stage counts of each unit
	localparam int DEPTH_LAT = Z_W + 1;
	localparam int BP_LAT    = 4;
	localparam int TF_LAT    = 3;
	localparam int PJ_LAT    = PROJ_QW + 4;
	localparam int TOTAL_LAT = DEPTH_LAT + BP_LAT + TF_LAT + PJ_LAT;

	// status codes
	localparam logic [ST_W-1:0] ST_WRITTEN  = 2'd0;
	localparam logic [ST_W-1:0] ST_LOW_DISP = 2'd1;
	localparam logic [ST_W-1:0] ST_BEHIND   = 2'd2;
	localparam logic [ST_W-1:0] ST_OUTSIDE  = 2'd3;

	// configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_NUM   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DISP_THR    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_CTR   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_IFOC  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z       = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODEL = 3'd7;

	// input request
	typedef struct packed {
		logic [COL_W-1:0]  column;
		logic [ROW_W-1:0]  row;
		logic [DISP_W-1:0] disparity;
	} item_t;

	// result
	typedef struct packed {
		logic [COL_W-1:0]       target_column;
		logic [ROW_W-1:0]       target_row;
		logic signed [PT_W-1:0] point_x;
		logic signed [PT_W-1:0] point_y;
		logic signed [PT_W-1:0] point_z;
		logic [ST_W-1:0]        status;
	} result_t;

	// pixel with depth, out of the depth divider
	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
		logic             reject;
		logic [Z_W-1:0]   z;
	} depth_t;

	// 3D point between back-projection, transform and projection
	typedef struct packed {
		logic                   reject;
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic signed [PT_W-1:0] z;
	} point_t;

endpackage

/* rtl/dtrp_depth.sv */
// Threshold check and pipelined restoring divider: depth = numerator * 256 / disparity.
module dtrp_depth (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  dtrp_pkg::item_t             in_item,
	input  logic [31:0]                 depth_numerator,
	input  logic [dtrp_pkg::DISP_W-1:0] disparity_threshold,
	output logic                        out_valid,
	output dtrp_pkg::depth_t            out_depth
);
	localparam int STEPS = dtrp_pkg::Z_W;
	localparam int DW    = dtrp_pkg::DISP_W;
	localparam int NUM_W = 40;

	typedef struct packed {
		logic [dtrp_pkg::COL_W-1:0] column;
		logic [dtrp_pkg::ROW_W-1:0] row;
		logic                       reject;
		logic                       ovf;
	} tag_t;

	logic [STEPS:0]   v_s;
	tag_t             tag_s  [0:STEPS];
	logic [DW-1:0]    rem_s  [0:STEPS];
	logic [DW-1:0]    dv_s   [0:STEPS];
	logic [STEPS-1:0] low_s  [0:STEPS];
	logic [STEPS-1:0] q_s    [0:STEPS];
	logic [DW:0]      trial  [0:STEPS-1];
	logic             fit    [0:STEPS-1];
	logic [NUM_W-1:0] num;
	logic             ovf_in;
	logic [STEPS-1:0] z_out;

	// quotient past 31 bits saturates; otherwise the top bits start below the divisor
	assign num    = {depth_numerator, 8'b0};
	assign ovf_in = {7'b0, num} >= {in_item.disparity, 31'b0};

	always_comb begin
		for (int k = 0; k < STEPS; k++) begin
			trial[k] = {rem_s[k], low_s[k][STEPS-1-k]};
			fit[k]   = trial[k] >= {1'b0, dv_s[k]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[STEPS-1:0], in_valid};
		end
	end

	// one quotient bit per stage
	always_ff @(posedge clk) begin
		tag_s[0] <= '{column: in_item.column, row: in_item.row,
			reject: in_item.disparity <= disparity_threshold, ovf: ovf_in};
		rem_s[0] <= DW'(num >> STEPS);
		low_s[0] <= num[STEPS-1:0];
		dv_s[0]  <= in_item.disparity;
		q_s[0]   <= '0;
		for (int k = 0; k < STEPS; k++) begin
			tag_s[k+1] <= tag_s[k];
			low_s[k+1] <= low_s[k];
			dv_s[k+1]  <= dv_s[k];
			rem_s[k+1] <= fit[k] ? DW'(trial[k] - {1'b0, dv_s[k]}) : trial[k][DW-1:0];
			q_s[k+1]   <= STEPS'({q_s[k], fit[k]});
		end
	end

	assign z_out     = tag_s[STEPS].ovf ? {STEPS{1'b1}} : q_s[STEPS];
	assign out_valid = v_s[STEPS];
	assign out_depth = '{column: tag_s[STEPS].column, row: tag_s[STEPS].row,
		reject: tag_s[STEPS].reject || (z_out == '0), z: z_out};

endmodule

/* rtl/dtrp_backproj.sv */
// Back-projection of a pixel with depth through the depth camera intrinsics.
module dtrp_backproj (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dtrp_pkg::depth_t in_depth,
	input  logic [31:0]      depth_center,
	input  logic [47:0]      depth_inverse_focal,
	output logic             out_valid,
	output dtrp_pkg::point_t out_pt
);
	localparam int ZW = dtrp_pkg::Z_W;

	logic [3:0]        v_s;
	logic [17:0]       dx, dy;
	logic              negx_s1, negy_s1, negx_s2, negy_s2, negx_s3, negy_s3;
	logic [15:0]       magx_s1, magy_s1;
	logic [ZW-1:0]     z_s1, z_s2, z_s3, z_s4;
	logic              rej_s1, rej_s2, rej_s3, rej_s4;
	logic [46:0]       ax_s2, ay_s2;
	logic [46:0]       hx_s3, hy_s3;
	logic [47:0]       lx_s3, ly_s3;
	logic [47:0]       sumx, sumy;
	logic [31:0]       x_s4, y_s4;

	// clamp a signed magnitude to 32 bits
	function automatic logic [31:0] sat_mag(input logic neg, input logic [43:0] q);
		logic [31:0] r;
		if (neg) begin
			r = (q > 44'h0_8000_0000) ? 32'h8000_0000 : 32'd0 - q[31:0];
		end else begin
			r = (q > 44'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
		end
		return r;
	endfunction

	// offset from the center in Q12.4
	assign dx = {4'b0, in_depth.column, 4'b0} - {2'b0, depth_center[15:0]};
	assign dy = {5'b0, in_depth.row, 4'b0} - {2'b0, depth_center[31:16]};

	// floor(a*inv / 2^24) split as high and low halves of a
	assign sumx = {1'b0, hx_s3} + {24'b0, lx_s3[47:24]};
	assign sumy = {1'b0, hy_s3} + {24'b0, ly_s3[47:24]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: sign and magnitude of the offset
		negx_s1 <= dx[17];
		negy_s1 <= dy[17];
		magx_s1 <= dx[17] ? 16'(18'd0 - dx) : dx[15:0];
		magy_s1 <= dy[17] ? 16'(18'd0 - dy) : dy[15:0];
		z_s1    <= in_depth.z;
		rej_s1  <= in_depth.reject;
		// stage 2: times depth
		ax_s2   <= magx_s1 * z_s1;
		ay_s2   <= magy_s1 * z_s1;
		negx_s2 <= negx_s1;
		negy_s2 <= negy_s1;
		z_s2    <= z_s1;
		rej_s2  <= rej_s1;
		// stage 3: times inverse focal length
		hx_s3   <= ax_s2[46:24] * depth_inverse_focal[23:0];
		lx_s3   <= ax_s2[23:0] * depth_inverse_focal[23:0];
		hy_s3   <= ay_s2[46:24] * depth_inverse_focal[47:24];
		ly_s3   <= ay_s2[23:0] * depth_inverse_focal[47:24];
		negx_s3 <= negx_s2;
		negy_s3 <= negy_s2;
		z_s3    <= z_s2;
		rej_s3  <= rej_s2;
		// stage 4: scale and saturate
		x_s4    <= sat_mag(negx_s3, sumx[47:4]);
		y_s4    <= sat_mag(negy_s3, sumy[47:4]);
		z_s4    <= z_s3;
		rej_s4  <= rej_s3;
	end

	assign out_valid = v_s[3];
	assign out_pt = '{reject: rej_s4, x: x_s4, y: y_s4, z: {1'b0, z_s4}};

endmodule

/* rtl/dtrp_transform.sv */
// Rigid 3x4 transform of a point into the color camera frame.
module dtrp_transform (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  dtrp_pkg::point_t in_pt,
	input  logic [63:0]      transform_row_x,
	input  logic [63:0]      transform_row_y,
	input  logic [63:0]      transform_row_z,
	output logic             out_valid,
	output dtrp_pkg::point_t out_pt
);
	logic [2:0]         v_s;
	logic [63:0]        rows    [0:2];
	logic signed [31:0] coords  [0:2];
	logic signed [47:0] prod_s1 [0:2][0:2];
	logic signed [50:0] acc_s2  [0:2];
	logic signed [36:0] sh      [0:2];
	logic signed [31:0] pt_s3   [0:2];
	logic               rej_s1, rej_s2, rej_s3;

	assign rows[0]   = transform_row_x;
	assign rows[1]   = transform_row_y;
	assign rows[2]   = transform_row_z;
	assign coords[0] = in_pt.x;
	assign coords[1] = in_pt.y;
	assign coords[2] = in_pt.z;

	// floor divide by 2^14 is an arithmetic shift
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			sh[r] = 37'(acc_s2[r] >>> 14);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: nine products, Q2.14 by Q16.16
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= $signed(rows[r][16*c +: 16]) * coords[c];
			end
		end
		rej_s1 <= in_pt.reject;
		// stage 2: row sums plus translation moved to Q.30
		for (int r = 0; r < 3; r++) begin
			acc_s2[r] <= 51'(prod_s1[r][0]) + 51'(prod_s1[r][1]) + 51'(prod_s1[r][2])
				+ (51'($signed(rows[r][63:48])) <<< 22);
		end
		rej_s2 <= rej_s1;
		// stage 3: back to Q16.16 with saturation
		for (int r = 0; r < 3; r++) begin
			if (sh[r][36:31] != {6{sh[r][31]}}) begin
				pt_s3[r] <= sh[r][36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
			end else begin
				pt_s3[r] <= sh[r][31:0];
			end
		end
		rej_s3 <= rej_s2;
	end

	assign out_valid = v_s[2];
	assign out_pt = '{reject: rej_s3, x: pt_s3[0], y: pt_s3[1], z: pt_s3[2]};

endmodule

/* rtl/dtrp_project.sv */
// Pinhole projection into the color image with a pipelined divider per axis, and status.
module dtrp_project (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  dtrp_pkg::point_t  in_pt,
	input  logic [63:0]       color_camera_model,
	output logic              out_valid,
	output dtrp_pkg::result_t out_res
);
	localparam int QW    = dtrp_pkg::PROJ_QW;
	localparam int NUM_W = 50;
	localparam int MAG_W = NUM_W - 1;
	localparam int DEN_W = 35;

	typedef struct packed {
		dtrp_pkg::point_t pt;
		logic             behind;
		logic             off;
	} tag_t;

	logic [QW+3:0]           v_s;
	dtrp_pkg::point_t        pt_s1, pt_s2;
	logic signed [48:0]      pfx_s1, pcx_s1, pfy_s1, pcy_s1;
	logic signed [NUM_W-1:0] numc_s2, numr_s2;
	logic [DEN_W-1:0]        den_s2;
	logic                    behind_s2;
	logic [MAG_W-1:0]        magc, magr;
	logic                    ovfc, ovfr;
	tag_t                    tag_s  [0:QW];
	logic [DEN_W-1:0]        den_s  [0:QW];
	logic [DEN_W-1:0]        rem_s  [0:1][0:QW];
	logic [QW-1:0]           low_s  [0:1][0:QW];
	logic [QW-1:0]           q_s    [0:1][0:QW];
	logic [DEN_W:0]          trial  [0:1][0:QW-1];
	logic                    fit    [0:1][0:QW-1];
	logic                    outside;
	dtrp_pkg::result_t       res_d;
	dtrp_pkg::result_t       res_q;

	assign magc = numc_s2[MAG_W-1:0];
	assign magr = numr_s2[MAG_W-1:0];
	assign ovfc = 64'(magc) >= (64'(den_s2) << QW);
	assign ovfr = 64'(magr) >= (64'(den_s2) << QW);

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			for (int k = 0; k < QW; k++) begin
				trial[a][k] = {rem_s[a][k], low_s[a][k][QW-1-k]};
				fit[a][k]   = trial[a][k] >= {1'b0, den_s[k]};
			end
		end
	end

	assign outside = tag_s[QW].off
		|| ({1'b0, q_s[0][QW]} >= (QW+1)'(dtrp_pkg::IMAGE_WIDTH))
		|| ({1'b0, q_s[1][QW]} >= (QW+1)'(dtrp_pkg::IMAGE_HEIGHT));

	// result and status from the last divider stage
	always_comb begin
		res_d = '0;
		if (tag_s[QW].pt.reject) begin
			res_d.status = dtrp_pkg::ST_LOW_DISP;
		end else begin
			res_d.point_x = tag_s[QW].pt.x;
			res_d.point_y = tag_s[QW].pt.y;
			res_d.point_z = tag_s[QW].pt.z;
			if (tag_s[QW].behind) begin
				res_d.status = dtrp_pkg::ST_BEHIND;
			end else if (outside) begin
				res_d.status = dtrp_pkg::ST_OUTSIDE;
			end else begin
				res_d.status        = dtrp_pkg::ST_WRITTEN;
				res_d.target_column = dtrp_pkg::COL_W'(q_s[0][QW]);
				res_d.target_row    = dtrp_pkg::ROW_W'(q_s[1][QW]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[QW+2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		// stage 1: focal and center products
		pfx_s1 <= $signed({1'b0, color_camera_model[15:0]}) * in_pt.x;
		pfy_s1 <= $signed({1'b0, color_camera_model[31:16]}) * in_pt.y;
		pcx_s1 <= $signed({1'b0, color_camera_model[47:32]}) * in_pt.z;
		pcy_s1 <= $signed({1'b0, color_camera_model[63:48]}) * in_pt.z;
		pt_s1  <= in_pt;
		// stage 2: numerators and denominator 16*z
		numc_s2   <= NUM_W'(pfx_s1) + NUM_W'(pcx_s1);
		numr_s2   <= NUM_W'(pfy_s1) + NUM_W'(pcy_s1);
		den_s2    <= {pt_s1.z[30:0], 4'b0};
		behind_s2 <= pt_s1.z[31] || (pt_s1.z == '0);
		pt_s2     <= pt_s1;
		// stage 3: negative or too large numerators are off image
		tag_s[0] <= '{pt: pt_s2, behind: behind_s2,
			off: numc_s2[NUM_W-1] || numr_s2[NUM_W-1] || ovfc || ovfr};
		den_s[0]    <= den_s2;
		rem_s[0][0] <= DEN_W'(magc >> QW);
		rem_s[1][0] <= DEN_W'(magr >> QW);
		low_s[0][0] <= magc[QW-1:0];
		low_s[1][0] <= magr[QW-1:0];
		q_s[0][0]   <= '0;
		q_s[1][0]   <= '0;
		// one quotient bit per stage on each axis
		for (int k = 0; k < QW; k++) begin
			tag_s[k+1] <= tag_s[k];
			den_s[k+1] <= den_s[k];
			for (int a = 0; a < 2; a++) begin
				low_s[a][k+1] <= low_s[a][k];
				rem_s[a][k+1] <= fit[a][k] ? DEN_W'(trial[a][k] - {1'b0, den_s[k]})
					: trial[a][k][DEN_W-1:0];
				q_s[a][k+1]   <= QW'({q_s[a][k], fit[a][k]});
			end
		end
		// result register
		res_q <= res_d;
	end

	assign out_valid = v_s[QW+3];
	assign out_res   = res_q;

endmodule

/* rtl/disparity_to_registered_point_core.sv */
// Top level: configuration registers and the registration pipeline.
//
// Takes one disparity pixel per clock and returns one result per pixel, in order, after the
// one-bit-per-stage depth divider, back-projection, the transform and projection, whose two
// dividers also retire one quotient bit per stage. busy never rises;
// done pulses for one cycle with the result and there is no way to hold it, so the receiver
// must take every result as it comes. Write configuration only while no pixel is in flight.
module disparity_to_registered_point_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  dtrp_pkg::item_t                item,
	output logic                           done,
	output dtrp_pkg::result_t              result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dtrp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                    cfg_data
);
	logic [31:0] depth_numerator_q;
	logic [15:0] disparity_threshold_q;
	logic [31:0] depth_center_q;
	logic [47:0] depth_inverse_focal_q;
	logic [63:0] transform_row_x_q, transform_row_y_q, transform_row_z_q;
	logic [63:0] color_camera_model_q;

	logic             dep_valid, bp_valid, tf_valid;
	dtrp_pkg::depth_t dep_out;
	dtrp_pkg::point_t bp_out, tf_out;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// configuration registers; transform resets to identity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_numerator_q     <= '0;
			disparity_threshold_q <= '0;
			depth_center_q        <= '0;
			depth_inverse_focal_q <= '0;
			transform_row_x_q     <= 64'h0000_0000_0000_4000;
			transform_row_y_q     <= 64'h0000_0000_4000_0000;
			transform_row_z_q     <= 64'h0000_4000_0000_0000;
			color_camera_model_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				dtrp_pkg::CFG_DEPTH_NUM:   depth_numerator_q     <= cfg_data[31:0];
				dtrp_pkg::CFG_DISP_THR:    disparity_threshold_q <= cfg_data[15:0];
				dtrp_pkg::CFG_DEPTH_CTR:   depth_center_q        <= cfg_data[31:0];
				dtrp_pkg::CFG_DEPTH_IFOC:  depth_inverse_focal_q <= cfg_data[47:0];
				dtrp_pkg::CFG_ROW_X:       transform_row_x_q     <= cfg_data;
				dtrp_pkg::CFG_ROW_Y:       transform_row_y_q     <= cfg_data;
				dtrp_pkg::CFG_ROW_Z:       transform_row_z_q     <= cfg_data;
				dtrp_pkg::CFG_COLOR_MODEL: color_camera_model_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	dtrp_depth u_depth (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (start && !busy),
		.in_item            (item),
		.depth_numerator    (depth_numerator_q),
		.disparity_threshold(disparity_threshold_q),
		.out_valid          (dep_valid),
		.out_depth          (dep_out)
	);

	dtrp_backproj u_backproj (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (dep_valid),
		.in_depth           (dep_out),
		.depth_center       (depth_center_q),
		.depth_inverse_focal(depth_inverse_focal_q),
		.out_valid          (bp_valid),
		.out_pt             (bp_out)
	);

	dtrp_transform u_transform (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (bp_valid),
		.in_pt          (bp_out),
		.transform_row_x(transform_row_x_q),
		.transform_row_y(transform_row_y_q),
		.transform_row_z(transform_row_z_q),
		.out_valid      (tf_valid),
		.out_pt         (tf_out)
	);

	dtrp_project u_project (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (tf_valid),
		.in_pt             (tf_out),
		.color_camera_model(color_camera_model_q),
		.out_valid         (done),
		.out_res           (result)
	);

	// every accepted request comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(dtrp_pkg::TOTAL_LAT) done)
		else $error("result missing after pipeline latency");

	// a written pixel's column lies inside the image width
	a_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == dtrp_pkg::ST_WRITTEN) |->
		(result.target_column < dtrp_pkg::COL_W'(dtrp_pkg::IMAGE_WIDTH)
		|| dtrp_pkg::IMAGE_WIDTH > (1 << dtrp_pkg::COL_W)))
		else $error("written target outside image");

	// results that are not written carry zero targets; low-disparity ones also carry a zero point
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != dtrp_pkg::ST_WRITTEN) |->
		(result.target_column == '0 && result.target_row == '0))
		else $error("non-written result carries targets");

	a_low_disp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == dtrp_pkg::ST_LOW_DISP) |->
		(result.point_x == '0 && result.point_y == '0 && result.point_z == '0))
		else $error("low disparity result carries a point");

endmodule
